FILE: rtl/b2d_pkg.sv
// ============================================================================
// b2d_pkg
// Shared constants and types of the binary to decimal ASCII converter.
// ============================================================================
package b2d_pkg;

    localparam int VALUE_W    = 64;
    localparam int BIN_W      = VALUE_W - 1;       // magnitude bits of a legal value
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 19;                // digits of the largest legal value
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int MAX_DIGITS = 19;                // longest text accepted (1..19)
    localparam int CHAR_W     = 6;
    localparam int COUNT_W    = 5;
    localparam int STEP_W     = $clog2(BIN_W);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ERROR_CHAR   = '0;
    localparam logic [DIGIT_W-1:0] ADD3_LIMIT   = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] ADD3_AMOUNT  = DIGIT_W'(3);
    localparam logic [STEP_W-1:0]  LAST_STEP    = STEP_W'(BIN_W - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT   = COUNT_W'(BCD_DIGITS);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT  = COUNT_W'(MAX_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT,
        ST_ERROR
    } b2d_state_t;

endpackage

FILE: rtl/b2d_if.sv
// ============================================================================
// b2d_if
// Valid/ready channels of the converter: number in, text digits out.
// ============================================================================
interface b2d_in_if import b2d_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if import b2d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              too_large;

    modport source (output valid, output digit_char, output last_digit, output too_large,
                    input ready);
    modport sink   (input valid, input digit_char, input last_digit, input too_large,
                    output ready);
endinterface

FILE: rtl/binary_to_decimal_ascii.sv
// ============================================================================
// binary_to_decimal_ascii
// Converts a 64-bit unsigned value to ASCII decimal digits, most significant
// first, no leading zeros, flagging the last digit and too-large values.
// ============================================================================
// Sequence: accept, 63 double-dabble steps through the shared add-3/shift unit,
// drop leading zeros and settle on the first digit, then emit the digits as
// the sink takes them; a too-large value instead gives one flagged output.
// Throughput: one item at a time; number.ready is high only while idle.
// Reset: rst_n asynchronous active low; clears the sequencer and output valid.
// ============================================================================
module binary_to_decimal_ascii import b2d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b2d_in_if.sink       number,
    b2d_out_if.source    text
);

    b2d_state_t          state_reg, state_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  remain_reg, remain_next;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic                out_err_reg, out_err_next;

    logic [BCD_W-1:0]    step_bcd;
    logic [DIGIT_W-1:0]  top_digit;
    logic [BCD_W-1:0]    bcd_shifted;
    logic                accept;
    logic                out_free;

    b2d_step u_step
    (
        .bcd     (bcd_reg),
        .bit_in  (bin_reg[BIN_W-1]),
        .bcd_out (step_bcd)
    );

    assign top_digit   = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign bcd_shifted = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    assign accept      = number.valid && number.ready;
    assign out_free    = !out_valid_reg || text.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = number.value[VALUE_W-1] ? ST_ERROR : ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == '0 && remain_reg > COUNT_W'(1))
                begin
                    state_next = ST_SKIP;
                end
                else if (remain_reg > COUNT_LIMIT)
                begin
                    state_next = ST_ERROR;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && remain_reg == COUNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        number.ready   = 1'b0;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                number.ready = 1'b1;
                bin_next     = number.value[BIN_W-1:0];
                bcd_next     = '0;
                step_next    = LAST_STEP;
                remain_next  = FULL_COUNT;
            end
            ST_CONVERT:
            begin
                bcd_next  = step_bcd;
                bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == '0 && remain_reg > COUNT_W'(1))
                begin
                    bcd_next    = bcd_shifted;
                    remain_next = remain_reg - COUNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASCII_ZERO + CHAR_W'(top_digit);
                    out_last_next  = (remain_reg == COUNT_W'(1));
                    out_err_next   = 1'b0;
                    bcd_next       = bcd_shifted;
                    remain_next    = remain_reg - COUNT_W'(1);
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ERROR_CHAR;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                end
            end
            default:
            begin
                number.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        step_reg     <= step_next;
        remain_reg   <= remain_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign text.valid      = out_valid_reg;
    assign text.digit_char = out_char_reg;
    assign text.last_digit = out_last_reg;
    assign text.too_large  = out_err_reg;

endmodule

FILE: rtl/b2d_step.sv
// ============================================================================
// b2d_step
// One double-dabble step: add 3 to every digit of 5 or more, then shift the
// BCD register left by one bit taking in the next binary bit.
// ============================================================================
module b2d_step import b2d_pkg::*;
(
    input  logic [BCD_W-1:0] bcd,
    input  logic             bit_in,
    output logic [BCD_W-1:0] bcd_out
);

    logic [BCD_W-1:0] adjusted;

    always_comb
    begin
        adjusted = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd[i*DIGIT_W +: DIGIT_W] >= ADD3_LIMIT)
            begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + ADD3_AMOUNT;
            end
        end
        bcd_out = {adjusted[BCD_W-2:0], bit_in};
    end

endmodule
